// ----- src/lsp_pkg.sv -----
// Shared types and constants for the laser scan to points block.
// CORDIC arctangent table, datapath widths, register map codes.
// No dependencies.
package lsp_pkg;

	localparam int XW = 35;          // CORDIC x/y datapath, Q16
	localparam int ZW = 33;          // CORDIC angle, 2^32 per turn
	localparam int RW = XW - 16;     // rounded whole-mm value
	localparam int PW = 17;          // output position
	localparam int TW = 28;          // time fields
	localparam int CW = 13;          // point count
	localparam int AW = 5;           // APB address

	localparam logic [15:0] GAIN_Q16  = 16'd39797;
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

	localparam logic [2:0] REG_RANGE_MIN  = 3'd0;
	localparam logic [2:0] REG_RANGE_MAX  = 3'd1;
	localparam logic [2:0] REG_ANGLE_MIN  = 3'd2;
	localparam logic [2:0] REG_ANGLE_INC  = 3'd3;
	localparam logic [2:0] REG_TIME_INC   = 3'd4;
	localparam logic [2:0] REG_USE_INTENS = 3'd5;

	localparam logic KIND_POINT   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [31:0] ATAN_TAB [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic          pnt;
		logic          sum;
		logic          flip;
		logic [15:0]   inten;
		logic [TW-1:0] tfs;
		logic [TW-1:0] dur;
		logic [CW-1:0] cnt;
	} meta_t;

	function automatic logic [PW-1:0] sat_pos(input logic signed [RW-1:0] v);
		logic [PW-1:0] r;
		priority if (v > RW'(65535)) begin
			r = PW'(65535);
		end else if (v < -RW'(65535)) begin
			r = -PW'(65535);
		end else begin
			r = v[PW-1:0];
		end
		return r;
	endfunction

endpackage

// ----- src/laser_scan_to_points_top.sv -----
// Laser scan to points: beam stream in, Cartesian point and scan summary stream out.
// Front state, range gate, CORDIC pipeline, output register, APB register file.
// Depends on lsp_pkg.

// Usage:
// Beams arrive on s_axis: tdata = {intensity, range}, tuser = echo flag,
// tlast = final beam of the scan. Results leave on m_axis: tuser = kind
// (point or summary), tlast = final result of the scan. A beam with an echo
// inside the configured range window gives one point; a final beam also gives a
// summary with the time of the last valid point and the point count.
// Registers are to be written over APB only while the block is idle; the block does not enforce it.
// Each result passes through the capture register, the scaling register, one
// pipeline register per CORDIC iteration, and the rounding and output registers.
// Throughput is one beam per cycle while m_axis does not stall; a final beam
// that also yields a point holds the input while both results leave through
// the single output register. When m_axis stalls the whole pipeline holds and
// s_axis_tready drops once the rounding stage is occupied. Reset returns the
// register file and scan state to their reset values and empties the pipeline;
// the next beam starts a scan.
module laser_scan_to_points_top
	import lsp_pkg::*;
#(
	parameter int MAX_BEAMS     = 4096,
	parameter int CORDIC_STAGES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [31:0]   s_axis_tdata,   // [15:0] range_mm, [31:16] beam_intensity
	input  logic          s_axis_tuser,   // [0] has_echo
	input  logic          s_axis_tlast,   // last_beam
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [119:0]  m_axis_tdata,   // [16:0] pos_x, [33:17] pos_y,
	                                      // [49:34] point_intensity,
	                                      // [77:50] time_from_start,
	                                      // [105:78] scan_duration,
	                                      // [118:106] point_count, [119] zero
	output logic          m_axis_tuser,   // [0] kind
	output logic          m_axis_tlast,   // last
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int IW = $clog2(MAX_BEAMS);
	localparam int NS = CORDIC_STAGES;

	// register file
	logic [15:0] rmin_q, rmax_q, amin_q, ainc_q, tinc_q;
	logic        useint_q;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmin_q   <= '0;
			rmax_q   <= 16'hFFFF;
			amin_q   <= '0;
			ainc_q   <= '0;
			tinc_q   <= '0;
			useint_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_RANGE_MIN:  rmin_q   <= pwdata[15:0];
				REG_RANGE_MAX:  rmax_q   <= pwdata[15:0];
				REG_ANGLE_MIN:  amin_q   <= pwdata[15:0];
				REG_ANGLE_INC:  ainc_q   <= pwdata[15:0];
				REG_TIME_INC:   tinc_q   <= pwdata[15:0];
				REG_USE_INTENS: useint_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RANGE_MIN:  prdata = 32'(rmin_q);
			REG_RANGE_MAX:  prdata = 32'(rmax_q);
			REG_ANGLE_MIN:  prdata = 32'(amin_q);
			REG_ANGLE_INC:  prdata = 32'(ainc_q);
			REG_TIME_INC:   prdata = 32'(tinc_q);
			REG_USE_INTENS: prdata = 32'(useint_q);
			default:        prdata = '0;
		endcase
	end

	// pipeline control
	logic adv, accept;
	logic h_pnt_q, h_sum_q;
	logic o_valid_q, out_ld;

	assign out_ld        = (!o_valid_q || m_axis_tready) && (h_pnt_q || h_sum_q);
	assign adv           = !(h_pnt_q || h_sum_q) || (out_ld && !(h_pnt_q && h_sum_q));
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;

	// scan state
	logic [IW-1:0] beam_idx_q;
	logic [15:0]   angle_q;
	logic [CW-1:0] count_q;
	logic          running_q;

	logic [15:0]   in_range, in_inten, cur_ang;
	logic          pv;
	logic [CW-1:0] cnt_new;

	assign in_range = s_axis_tdata[15:0];
	assign in_inten = s_axis_tdata[31:16];
	assign cur_ang  = running_q ? angle_q : amin_q;
	assign pv       = s_axis_tuser && (rmin_q <= in_range) && (in_range <= rmax_q);
	assign cnt_new  = (pv && count_q != CNT_MAX) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_idx_q <= '0;
			angle_q    <= '0;
			count_q    <= '0;
			running_q  <= 1'b0;
		end else if (accept) begin
			angle_q <= cur_ang + ainc_q;
			if (s_axis_tlast) begin
				beam_idx_q <= '0;
				count_q    <= '0;
				running_q  <= 1'b0;
			end else begin
				if (beam_idx_q < IW'(MAX_BEAMS - 1))
					beam_idx_q <= beam_idx_q + 1'b1;
				count_q    <= cnt_new;
				running_q  <= 1'b1;
			end
		end
	end

	// stage 1: captured beam
	logic          v_s1, pnt_s1, sum_s1;
	logic [15:0]   range_s1, ang_s1, inten_s1;
	logic [IW-1:0] idx_s1;
	logic [CW-1:0] cnt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= accept && (pv || s_axis_tlast);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pnt_s1   <= pv;
			sum_s1   <= s_axis_tlast;
			range_s1 <= in_range;
			ang_s1   <= cur_ang;
			inten_s1 <= useint_q ? in_inten : 16'd0;
			idx_s1   <= beam_idx_q;
			cnt_s1   <= cnt_new;
		end
	end

	// stage 2: quadrant fold, gain scaling, times
	logic signed [16:0] a_ext, a_fold;
	logic               flip;
	logic [31:0]        xprod;
	logic [IW+15:0]     tprod;
	logic [TW-1:0]      t_now, dur_new, lvt_q;

	always_comb begin
		a_ext = 17'($signed(ang_s1));
		priority if (a_ext > 17'sd16384) begin
			a_fold = a_ext - 17'sd32768;
			flip   = 1'b1;
		end else if (a_ext < -17'sd16384) begin
			a_fold = a_ext + 17'sd32768;
			flip   = 1'b1;
		end else begin
			a_fold = a_ext;
			flip   = 1'b0;
		end
	end

	assign xprod   = 32'(range_s1) * 32'(GAIN_Q16);
	assign tprod   = (IW+16)'(idx_s1) * (IW+16)'(tinc_q);
	assign t_now   = TW'(tprod);
	assign dur_new = pnt_s1 ? t_now : lvt_q;

	// time of the last valid point in the running scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lvt_q <= '0;
		else if (adv && v_s1) begin
			if (sum_s1)
				lvt_q <= '0;
			else if (pnt_s1)
				lvt_q <= t_now;
		end
	end

	logic                 cv_s [NS+1];
	logic signed [XW-1:0] cx_s [NS+1];
	logic signed [XW-1:0] cy_s [NS+1];
	logic signed [ZW-1:0] cz_s [NS+1];
	meta_t                meta_s [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cv_s[0] <= 1'b0;
		else if (adv)
			cv_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s[0]   <= $signed(XW'(xprod));
			cy_s[0]   <= '0;
			cz_s[0]   <= ZW'(a_fold) <<< 16;
			meta_s[0] <= '{pnt: pnt_s1, sum: sum_s1, flip: flip, inten: inten_s1,
				tfs: t_now, dur: dur_new, cnt: cnt_s1};
		end
	end

	// CORDIC rotation, one iteration per stage
	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic signed [ZW-1:0] at;
		logic signed [XW-1:0] xs, ys;

		assign at = $signed(ZW'(ATAN_TAB[i]));
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cv_s[i+1] <= 1'b0;
			else if (adv)
				cv_s[i+1] <= cv_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				meta_s[i+1] <= meta_s[i];
				if (!cz_s[i][ZW-1]) begin
					cx_s[i+1] <= cx_s[i] - ys;
					cy_s[i+1] <= cy_s[i] + xs;
					cz_s[i+1] <= cz_s[i] - at;
				end else begin
					cx_s[i+1] <= cx_s[i] + ys;
					cy_s[i+1] <= cy_s[i] - xs;
					cz_s[i+1] <= cz_s[i] + at;
				end
			end
		end
	end

	// rounding, unfold and saturation into the holding stage
	logic signed [XW-1:0] xsum, ysum, xsh, ysh;
	logic signed [RW-1:0] xr, yr;
	logic [PW-1:0]        h_x_q, h_y_q;
	meta_t                h_meta_q;

	assign xsum = cx_s[NS] + XW'(32768);
	assign ysum = cy_s[NS] + XW'(32768);
	assign xsh  = xsum >>> 16;
	assign ysh  = ysum >>> 16;
	assign xr   = meta_s[NS].flip ? -xsh[RW-1:0] : xsh[RW-1:0];
	assign yr   = meta_s[NS].flip ? -ysh[RW-1:0] : ysh[RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_pnt_q <= 1'b0;
			h_sum_q <= 1'b0;
		end else if (adv) begin
			h_pnt_q <= cv_s[NS] && meta_s[NS].pnt;
			h_sum_q <= cv_s[NS] && meta_s[NS].sum;
		end else if (out_ld) begin
			if (h_pnt_q)
				h_pnt_q <= 1'b0;
			else
				h_sum_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_x_q    <= sat_pos(xr);
			h_y_q    <= sat_pos(yr);
			h_meta_q <= meta_s[NS];
		end
	end

	// output register
	logic          o_kind_q, o_last_q;
	logic [PW-1:0] o_x_q, o_y_q;
	logic [15:0]   o_inten_q;
	logic [TW-1:0] o_tfs_q, o_dur_q;
	logic [CW-1:0] o_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			o_valid_q <= 1'b0;
		else if (!o_valid_q || m_axis_tready)
			o_valid_q <= h_pnt_q || h_sum_q;
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			if (h_pnt_q) begin
				o_kind_q  <= KIND_POINT;
				o_x_q     <= h_x_q;
				o_y_q     <= h_y_q;
				o_inten_q <= h_meta_q.inten;
				o_tfs_q   <= h_meta_q.tfs;
				o_dur_q   <= '0;
				o_cnt_q   <= '0;
				o_last_q  <= 1'b0;
			end else begin
				o_kind_q  <= KIND_SUMMARY;
				o_x_q     <= '0;
				o_y_q     <= '0;
				o_inten_q <= '0;
				o_tfs_q   <= '0;
				o_dur_q   <= h_meta_q.dur;
				o_cnt_q   <= h_meta_q.cnt;
				o_last_q  <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tuser  = o_kind_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {1'b0, o_cnt_q, o_dur_q, o_tfs_q, o_inten_q, o_y_q, o_x_q};

`ifndef ASSERT_OFF
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("summary transaction without tlast");

	a_point_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> !m_axis_tlast && m_axis_tdata[118:78] == '0)
		else $error("point transaction carries summary fields");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (h_pnt_q || h_sum_q))
		else $error("input stalled with empty holding stage");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=>
			!running_q && beam_idx_q == '0 && count_q == '0)
		else $error("scan state not cleared after final beam");
`endif

endmodule
